FILE: hdl/tsl_pkg.sv
package tsl_pkg;

  // Default build sizes
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int ID_BITS_DEF     = 16;

  // Fixed field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Register index, taken from paddr bit 2
  localparam logic REG_SORT_DESC = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  // Reset values of the registers
  localparam logic             SORT_DESC_RST = 1'b1;
  localparam logic [CAP_W-1:0] CAPACITY_RST  = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } tsl_state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic in_ready;
    logic load;
    logic cmp_en;
    logic upd_en;
  } tsl_ctrl_t;

endpackage

FILE: hdl/top_n_sorted_insert_list_core.sv
// Bounded top-k list: keeps up to capacity (id, key) words in a row of cells,
// best key first (largest when sort_descending is 1, smallest when 0). Each
// input word carries an action in in_tuser: clear, insert or read; every word
// gives exactly one result word with the read entry, a valid flag and the
// entry count. An item goes through steps: one to register it, one in which every
// cell compares its key with the new one, and one in which the insert position
// ripples down the cell row and all cells shift or load together. The result
// word is registered in the last step and held on the output until taken. A new
// word is accepted only after the previous result is produced, from the cycle
// after it on, while that result may still wait in the output register; if the
// previous result is still not taken, the compare step holds. No clearing
// pass is needed after reset. Registers: sort_descending at 0x0, capacity at
// 0x4 (0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES; lowering it
// drops tail entries at once).
module top_n_sorted_insert_list_core import tsl_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int IN_W        = ((ID_BITS + KEY_BITS + IDX_W + 7) / 8) * 8,
  parameter int OUT_W       = ((ID_BITS + KEY_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // item_id, item_key, read_index
  input  logic [IN_W-1:0]   in_tdata,
  // action
  input  logic [ACT_W-1:0]  in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // out_id, out_key, entry_count
  output logic [OUT_W-1:0]  out_tdata,
  // out_valid
  output logic              out_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int MAX_W = $clog2(MAX_ENTRIES) + 1;
  localparam int CMP_W = (MAX_W > CNT_W) ? MAX_W : CNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  tsl_ctrl_t ctrl;

  // Configuration and count registers
  logic             sort_desc_r;
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] held_r, held_nxt;

  // Item registers
  logic [ACT_W-1:0]    act_r;
  logic [ID_BITS-1:0]  item_id_r;
  logic [KEY_BITS-1:0] item_key_r;
  logic [IDX_W-1:0]    read_idx_r;

  // Result registers
  logic                out_valid_r;
  logic [ID_BITS-1:0]  out_id_r, out_id_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_flag_r, out_flag_nxt;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [KEY_BITS-1:0] cell_key [MAX_ENTRIES];
  logic [ID_BITS-1:0]  cell_id  [MAX_ENTRIES];
  logic                cell_better [MAX_ENTRIES];
  logic [MAX_ENTRIES:0] found;

  logic [CMP_W-1:0] count_w, eff_w, n_new_w, tail_w, wcap_eff_w, read_w;
  logic             full, tail_better, ins_en, cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // Effective capacity of the current register and of a value being written
  function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    c = CMP_W'(cap);
    if (cap == '0) begin
      return CMP_W'(1);
    end else if (c > MAX_CMP) begin
      return MAX_CMP;
    end
    return c;
  endfunction

  assign eff_w      = eff_cap(capacity_r);
  assign wcap_eff_w = eff_cap(cfg_pwdata[CAP_W-1:0]);

  // Register read
  always_comb begin
    case (cfg_paddr[2])
      REG_SORT_DESC: cfg_prdata = APB_DW'(sort_desc_r);
      REG_CAPACITY:  cfg_prdata = APB_DW'(capacity_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_desc_r <= SORT_DESC_RST;
      capacity_r  <= CAPACITY_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SORT_DESC) begin
        sort_desc_r <= cfg_pwdata[0];
      end else begin
        capacity_r <= cfg_pwdata[CAP_W-1:0];
      end
    end
  end

  // Sequencer
  tsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_valid_r & ~out_tready),
    .ctrl     (ctrl)
  );

  assign in_tready = ctrl.in_ready;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      act_r      <= in_tuser;
      item_id_r  <= in_tdata[ID_BITS-1:0];
      item_key_r <= in_tdata[ID_BITS +: KEY_BITS];
      read_idx_r <= in_tdata[ID_BITS+KEY_BITS +: IDX_W];
    end
  end

  // Insert bookkeeping
  assign count_w = CMP_W'(held_r);
  assign full    = (count_w >= eff_w);
  assign n_new_w = full ? count_w : count_w + CMP_W'(1);
  assign tail_w  = count_w - CMP_W'(1);

  always_comb begin
    tail_better = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tail_better = tail_better | ((CMP_W'(i) == tail_w) & cell_better[i]);
    end
  end

  assign ins_en = ctrl.upd_en && (act_r == ACT_INSERT) && (!full || tail_better);

  // Row of cells
  assign found[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0] lk;
    logic [ID_BITS-1:0]  li;
    if (g == 0) begin : g_head
      assign lk = item_key_r;
      assign li = item_id_r;
    end else begin : g_body
      assign lk = cell_key[g-1];
      assign li = cell_id[g-1];
    end
    tsl_cell #(
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS),
      .CMP_W    (CMP_W),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .descending (sort_desc_r),
      .new_key    (item_key_r),
      .new_id     (item_id_r),
      .count      (count_w),
      .n_new      (n_new_w),
      .left_key   (lk),
      .left_id    (li),
      .found_in   (found[g]),
      .cmp_en     (ctrl.cmp_en),
      .ins_en     (ins_en),
      .key        (cell_key[g]),
      .id         (cell_id[g]),
      .found_out  (found[g+1]),
      .better     (cell_better[g])
    );
  end

  // Held count: clear, grow on insert, cut on a lower capacity
  always_comb begin
    held_nxt = held_r;
    if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      if (count_w > wcap_eff_w) held_nxt = CNT_W'(wcap_eff_w);
    end else if (ctrl.upd_en && (act_r == ACT_CLEAR)) begin
      held_nxt = '0;
    end else if (ins_en) begin
      held_nxt = CNT_W'(n_new_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // Read select
  assign read_w = CMP_W'(read_idx_r);

  always_comb begin
    out_id_nxt   = '0;
    out_key_nxt  = '0;
    out_flag_nxt = (act_r == ACT_READ) && (read_w < count_w) && (read_w < MAX_CMP);
    if (out_flag_nxt) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (CMP_W'(i) == read_w) begin
          out_id_nxt  = cell_id[i];
          out_key_nxt = cell_key[i];
        end
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (ctrl.upd_en) begin
      out_id_r   <= out_id_nxt;
      out_key_r  <= out_key_nxt;
      out_flag_r <= out_flag_nxt;
      out_cnt_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_flag_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_key_r, out_id_r});

endmodule

FILE: hdl/tsl_cell.sv
module tsl_cell import tsl_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int CMP_W    = 8,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                descending,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [ID_BITS-1:0]  new_id,
  input  logic [CMP_W-1:0]    count,
  input  logic [CMP_W-1:0]    n_new,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic                found_in,
  input  logic                cmp_en,
  input  logic                ins_en,
  output logic [KEY_BITS-1:0] key,
  output logic [ID_BITS-1:0]  id,
  output logic                found_out,
  output logic                better
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [KEY_BITS-1:0] key_r;
  logic [ID_BITS-1:0]  id_r;
  logic                hit_r, hit_nxt;
  logic                better_r, better_nxt;

  // Compare the new key against the held one
  always_comb begin
    better_nxt = descending ? (new_key > key_r) : (new_key < key_r);
    hit_nxt    = ((MY_IDX < count) && (better_nxt || (new_key == key_r))) ||
                 (MY_IDX == count);
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_r    <= hit_nxt;
      better_r <= better_nxt;
    end
  end

  // Shift from the left neighbor past the insert point, take the new word at it
  always_ff @(posedge clk) begin
    if (ins_en && (MY_IDX < n_new)) begin
      if (found_in) begin
        key_r <= left_key;
        id_r  <= left_id;
      end else if (hit_r) begin
        key_r <= new_key;
        id_r  <= new_id;
      end
    end
  end

  assign found_out = found_in | hit_r;
  assign key       = key_r;
  assign id        = id_r;
  assign better    = better_r;

endmodule

FILE: hdl/tsl_ctrl.sv
module tsl_ctrl import tsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_busy,
  output tsl_ctrl_t ctrl
);

  tsl_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  if (!out_busy) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load     = in_valid;
      end
      ST_CMP:  ctrl.cmp_en = 1'b1;
      ST_UPD:  ctrl.upd_en = 1'b1;
      default: ctrl = '0;
    endcase
  end

endmodule

FILE: hdl/tsl_checker.sv
module tsl_checker import tsl_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int OUT_W       = ((ID_BITS + KEY_BITS + CNT_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic              out_tuser,
  input logic              out_tvalid,
  input logic              out_tready
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // Entry count never exceeds the list size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ID_BITS+KEY_BITS +: CNT_W] <= CNT_W'(MAX_ENTRIES)))
    else $error("entry count above list size");

  // A result without the valid flag carries zero id and key
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[ID_BITS+KEY_BITS-1:0] == '0))
    else $error("nonzero entry on an invalid result");

  // A valid read comes from a nonempty list
  a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[ID_BITS+KEY_BITS +: CNT_W] != '0))
    else $error("valid read from an empty list");

endmodule

bind top_n_sorted_insert_list_core tsl_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .KEY_BITS    (KEY_BITS),
  .ID_BITS     (ID_BITS),
  .OUT_W       (OUT_W)
) u_tsl_checker (.*);

FILE: dv/top_n_sorted_insert_list_core_tb.sv
module top_n_sorted_insert_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsl_pkg::*;

  localparam int KEY_W = KEY_BITS_DEF;
  localparam int ID_W  = ID_BITS_DEF;
  localparam int IN_W  = ((ID_W + KEY_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_W = ((ID_W + KEY_W + CNT_W + 7) / 8) * 8;
  localparam int MAX_GAP = 18;
  localparam int N_PHASES = 9;
  localparam int WORDS_PER_PHASE = 103;

  // Action code that the block leaves unused; it must act as a no-op
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } list_word_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             valid;
    logic [CNT_W-1:0] count;
  } list_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [IN_W-1:0]   in_tdata = '0;    // item_id, item_key, read_index
  logic [ACT_W-1:0]  in_tuser = '0;    // action
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;        // out_id, out_key, entry_count
  logic              out_tuser;        // out_valid
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  top_n_sorted_insert_list_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the list and its registers
  logic [KEY_W-1:0] held_keys [MAX_ENTRIES_DEF];
  logic [ID_W-1:0]  held_ids  [MAX_ENTRIES_DEF];
  int               held_cnt = 0;
  logic             desc_order = SORT_DESC_RST;
  logic [CAP_W-1:0] cap_reg = CAPACITY_RST;

  list_word_t   words_to_send [$];
  list_answer_t answers_due [$];
  list_word_t   word_in_flight;

  int fail_count = 0;
  int words_sent = 0;
  int answers_seen = 0;
  int placed_cnt = 0;
  int dropped_cnt = 0;
  int valid_reads = 0;
  int reg_writes = 0;

  logic [CAP_W-1:0] phase_caps [N_PHASES] = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd3,
                                              7'd17, 7'd64, 7'd40};

  function automatic int lim_now();
    if (cap_reg == 0) return 1;
    if (cap_reg > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
    return int'(cap_reg);
  endfunction

  // True when key a strictly outranks key b under the current direction
  function automatic bit outranks(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return desc_order ? (a > b) : (a < b);
  endfunction

  function automatic void shadow_insert(logic [KEY_W-1:0] key, logic [ID_W-1:0] id);
    int lim;
    int n;
    int pos;
    int last;
    lim = lim_now();
    n = (held_cnt > lim) ? lim : held_cnt;
    // Full list: drop unless the new key strictly beats the tail
    if (n >= lim && !outranks(key, held_keys[n-1])) begin
      dropped_cnt++;
      return;
    end
    // Go in ahead of the first entry that the new key ties or beats
    pos = 0;
    while (pos < n && !(key == held_keys[pos] || outranks(key, held_keys[pos])))
      pos++;
    last = (n < lim) ? n : n - 1;
    for (int j = last; j > pos; j--) begin
      held_keys[j] = held_keys[j-1];
      held_ids[j]  = held_ids[j-1];
    end
    held_keys[pos] = key;
    held_ids[pos]  = id;
    if (n < lim) n++;
    held_cnt = n;
    placed_cnt++;
  endfunction

  // Advance the shadow list by one word and return the answer it gives
  function automatic list_answer_t list_step(list_word_t w);
    list_answer_t a;
    a = '0;
    case (w.action)
      ACT_CLEAR: held_cnt = 0;
      ACT_INSERT: shadow_insert(w.key, w.id);
      ACT_READ: begin
        if (w.idx < held_cnt) begin
          a.id    = held_ids[w.idx];
          a.key   = held_keys[w.idx];
          a.valid = 1'b1;
          valid_reads++;
        end
      end
      default: ;
    endcase
    a.count = held_cnt[CNT_W-1:0];
    return a;
  endfunction

  task automatic check_answer(list_answer_t got);
    list_answer_t want;
    answers_seen++;
    if (answers_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] result word with nothing pending: id=%h key=%h valid=%b count=%0d",
                 $time, got.id, got.key, got.valid, got.count);
      return;
    end
    want = answers_due.pop_front();
    if (got.id !== want.id || got.key !== want.key || got.valid !== want.valid ||
        got.count !== want.count) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] mismatch: want id=%h key=%h valid=%b count=%0d",
                 $time, want.id, want.key, want.valid, want.count);
        $display("[%0t]           got  id=%h key=%h valid=%b count=%0d",
                 $time, got.id, got.key, got.valid, got.count);
      end
    end
  endtask

  // Input side: present queued words with random gaps between them
  bit in_gappy = 1'b1;
  bit sending;
  int in_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      sending = in_tvalid;
      if (in_tvalid && in_tready) begin
        answers_due.push_back(list_step(word_in_flight));
        words_sent++;
        sending = 1'b0;
        if ($urandom_range(0, 29) == 0) in_gappy = !in_gappy;
        in_wait = in_gappy ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!sending) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (words_to_send.size() > 0) begin
          word_in_flight = words_to_send.pop_front();
          in_tuser <= word_in_flight.action;
          in_tdata <= IN_W'({word_in_flight.idx, word_in_flight.key, word_in_flight.id});
          sending = 1'b1;
        end
      end
      in_tvalid <= sending;
    end
  end

  // Result side: take words and stall for random stretches
  bit out_gappy = 1'b0;
  int out_hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_answer({out_tdata[ID_W-1:0], out_tdata[ID_W+KEY_W-1:ID_W], out_tuser,
                      out_tdata[ID_W+KEY_W+CNT_W-1:ID_W+KEY_W]});
        if ($urandom_range(0, 29) == 0) out_gappy = !out_gappy;
        out_hold = out_gappy ? $urandom_range(0, MAX_GAP) : 0;
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_tready <= (out_hold == 0);
    end
  end

  task automatic add_word(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                          logic [IDX_W-1:0] idx);
    list_word_t w;
    w.action = act;
    w.id     = id;
    w.key    = key;
    w.idx    = idx;
    words_to_send.push_back(w);
  endtask

  // Hold until every word is sent and answered, then let the pipeline drain
  task automatic wait_idle();
    while (words_to_send.size() > 0 || sending || answers_due.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_sel, logic [APB_DW-1:0] value);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_SORT_DESC) begin
      desc_order = value[0];
    end else begin
      cap_reg = value[CAP_W-1:0];
      // Lowering the capacity cuts the tail at once
      if (held_cnt > lim_now()) held_cnt = lim_now();
    end
    reg_writes++;
  endtask

  // Keys bunched at both ends so that ties and extremes come up often
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 31));
      4, 5: return ~KEY_W'($urandom_range(0, 31));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [APB_DW-1:0] rnd;
    logic [ACT_W-1:0]  act;
    int                r;
    int                top_idx;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, extreme keys and ids, ties, the unused action, clear
    add_word(ACT_READ, 16'h0000, 32'h0, 6'd0);
    add_word(ACT_READ, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    add_word(ACT_INSERT, 16'hFFFF, 32'h0000_0000, 6'd63);
    add_word(ACT_INSERT, 16'h0000, 32'hFFFF_FFFF, 6'd0);
    add_word(ACT_INSERT, 16'h1234, 32'h0000_0000, 6'd0);
    add_word(ACT_NOP, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd1);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd2);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd3);
    add_word(ACT_CLEAR, 16'hA5A5, 32'h5A5A_5A5A, 6'd21);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);

    // Full list: worse and equal keys drop, a better key pushes the tail out
    cfg_write(REG_CAPACITY, 32'd2);
    add_word(ACT_INSERT, 16'h0010, 32'd10, 6'd0);
    add_word(ACT_INSERT, 16'h0020, 32'd20, 6'd0);
    add_word(ACT_INSERT, 16'h0005, 32'd5, 6'd0);
    add_word(ACT_INSERT, 16'h0011, 32'd10, 6'd0);
    add_word(ACT_INSERT, 16'h0015, 32'd15, 6'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd1);

    // Flip the direction with entries held; the list stays as it is
    cfg_write(REG_SORT_DESC, 32'd0);
    add_word(ACT_INSERT, 16'h0017, 32'd17, 6'd0);
    add_word(ACT_INSERT, 16'h0001, 32'd1, 6'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);

    // Capacity zero acts as one and cuts the list
    cfg_write(REG_CAPACITY, 32'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd1);
    add_word(ACT_INSERT, 16'h0000, 32'd0, 6'd0);

    // Capacity above the array size acts as the array size
    cfg_write(REG_CAPACITY, 32'd127);
    add_word(ACT_READ, 16'h0, 32'h0, 6'd0);

    // Random phases, each under its own direction and capacity
    for (int ph = 0; ph < N_PHASES; ph++) begin
      rnd = $urandom();
      cfg_write(REG_SORT_DESC, {rnd[APB_DW-1:1], ph[0]});
      rnd = $urandom();
      cfg_write(REG_CAPACITY, {rnd[APB_DW-1:CAP_W], phase_caps[ph]});
      top_idx = (lim_now() < 63) ? lim_now() : 63;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) act = ACT_CLEAR;
        else if (r < 5) act = ACT_NOP;
        else if (r < 55) act = ACT_INSERT;
        else act = ACT_READ;
        add_word(act, ID_W'($urandom_range(0, 65535)), pick_key(),
                 ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 63))
                                            : IDX_W'($urandom_range(0, top_idx)));
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    $display("Sent %0d words and checked %0d results over %0d register writes", words_sent,
             answers_seen, reg_writes);
    $display("Inserts: %0d placed, %0d dropped; %0d reads hit a held entry", placed_cnt,
             dropped_cnt, valid_reads);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
